// ----- hw/rtl/pfra_pkg.sv -----
package pfra_pkg;

  localparam int NUM_FRAMES  = 3840;
  localparam int IDX_W       = $clog2(NUM_FRAMES);
  localparam int FRAME_SHIFT = 12;
  localparam int FRAME_BASE  = 32'h0010_0000;
  localparam int BASE_PAGE   = FRAME_BASE >> FRAME_SHIFT;
  localparam int ADDR_W      = 32;
  localparam int PAGE_W      = ADDR_W - FRAME_SHIFT;
  localparam int CFG_W       = 25;
  localparam int NRES_W      = CFG_W - FRAME_SHIFT;
  localparam int CMP_W       = (IDX_W > NRES_W) ? IDX_W : NRES_W;
  localparam int COUNT_W     = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COUNT_W-1:0] RESERVED_COUNT = 8'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

  localparam logic [CFG_W-1:0] RESERVED_END_RST = 25'h010_0000;
  localparam logic [CFG_W-1:0] MEMORY_END_RST   = 25'h100_0000;

  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_END = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_END   = 2'd1;

  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_FREE  = 3'd1;
  localparam logic [2:0] OP_SHARE = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_INIT  = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_FREE      = 3'd1;
  localparam logic [2:0] ST_RANGE        = 3'd2;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [2:0] ST_SATURATED    = 3'd4;

  localparam logic [2:0] IDX_HOLD = 3'd0;
  localparam logic [2:0] IDX_ZERO = 3'd1;
  localparam logic [2:0] IDX_TOP  = 3'd2;
  localparam logic [2:0] IDX_INC  = 3'd3;
  localparam logic [2:0] IDX_DEC  = 3'd4;

  localparam logic [1:0] RD_FRAME = 2'd0;
  localparam logic [1:0] RD_TOP   = 2'd1;
  localparam logic [1:0] RD_DOWN  = 2'd2;

  localparam logic [1:0] WR_ZERO   = 2'd0;
  localparam logic [1:0] WR_FILL   = 2'd1;
  localparam logic [1:0] WR_ONE    = 2'd2;
  localparam logic [1:0] WR_UPDATE = 2'd3;

  localparam logic [2:0] RES_OK      = 3'd0;
  localparam logic [2:0] RES_UPDATE  = 3'd1;
  localparam logic [2:0] RES_FOUND   = 3'd2;
  localparam logic [2:0] RES_NO_FREE = 3'd3;
  localparam logic [2:0] RES_RANGE   = 3'd4;

  localparam logic [IDX_W-1:0] IDX_TOP_VAL = IDX_W'(NUM_FRAMES - 1);

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] page_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  frame_address;
    logic [COUNT_W-1:0] ref_count;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic       cmd_load;
    logic [2:0] idx_op;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       res_load;
    logic [2:0] res_sel;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       in_range;
    logic       rd_zero;
    logic       idx_zero;
    logic       idx_top;
  } stat_t;

endpackage

// ----- hw/rtl/pfra_ram.sv -----
module pfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pfra_dp.sv -----
module pfra_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfra_pkg::in_item_t                  in_item_i,
  input  logic                                cfg_write_i,
  input  logic [pfra_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfra_pkg::CFG_W-1:0]          cfg_data_i,
  input  pfra_pkg::ctrl_t                     ctrl_i,
  output pfra_pkg::stat_t                     stat_o,
  output pfra_pkg::out_item_t                 result_o,
  output logic                                result_valid_o
);

  logic [2:0]                      op_q;
  logic [pfra_pkg::ADDR_W-1:0]     addr_q;
  logic [pfra_pkg::CFG_W-1:0]      res_end_q;
  logic [pfra_pkg::CFG_W-1:0]      mem_end_q;
  logic [pfra_pkg::IDX_W-1:0]      idx_q, idx_d;
  pfra_pkg::out_item_t             result_q, result_d;
  logic                            valid_q;

  logic [pfra_pkg::PAGE_W-1:0]     page;
  logic [pfra_pkg::PAGE_W-1:0]     frame_off;
  logic                            in_range;
  logic [pfra_pkg::IDX_W-1:0]      frame_idx;
  logic [pfra_pkg::NRES_W-1:0]     res_page;
  logic [pfra_pkg::NRES_W-1:0]     nres;
  logic [pfra_pkg::COUNT_W-1:0]    fill_val;
  logic [pfra_pkg::COUNT_W-1:0]    rdata;
  logic [pfra_pkg::COUNT_W-1:0]    new_count;
  logic [2:0]                      upd_status;
  logic [pfra_pkg::IDX_W-1:0]      raddr;
  logic [pfra_pkg::IDX_W-1:0]      waddr;
  logic [pfra_pkg::COUNT_W-1:0]    wdata;
  logic [pfra_pkg::PAGE_W-1:0]     found_page;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd_load) begin
      op_q   <= in_item_i.op;
      addr_q <= in_item_i.page_address;
    end
    if (ctrl_i.res_load) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_end_q <= pfra_pkg::RESERVED_END_RST;
      mem_end_q <= pfra_pkg::MEMORY_END_RST;
      idx_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (cfg_write_i && cfg_index_i == pfra_pkg::REG_RESERVED_END) begin
        res_end_q <= cfg_data_i;
      end
      if (cfg_write_i && cfg_index_i == pfra_pkg::REG_MEMORY_END) begin
        mem_end_q <= cfg_data_i;
      end
      idx_q   <= idx_d;
      valid_q <= ctrl_i.res_load;
    end
  end

  always_comb begin
    case (ctrl_i.idx_op)
      pfra_pkg::IDX_ZERO: idx_d = '0;
      pfra_pkg::IDX_TOP:  idx_d = pfra_pkg::IDX_TOP_VAL;
      pfra_pkg::IDX_INC:  idx_d = idx_q + 1'b1;
      pfra_pkg::IDX_DEC:  idx_d = idx_q - 1'b1;
      default:            idx_d = idx_q;
    endcase
  end

  assign page      = addr_q[pfra_pkg::ADDR_W-1:pfra_pkg::FRAME_SHIFT];
  assign frame_off = page - pfra_pkg::PAGE_W'(pfra_pkg::BASE_PAGE);
  assign in_range  = (page >= pfra_pkg::PAGE_W'(pfra_pkg::BASE_PAGE))
                  && ({page, {pfra_pkg::FRAME_SHIFT{1'b0}}}
                      < pfra_pkg::ADDR_W'(mem_end_q))
                  && (frame_off < pfra_pkg::PAGE_W'(pfra_pkg::NUM_FRAMES));
  assign frame_idx = frame_off[pfra_pkg::IDX_W-1:0];

  assign res_page = res_end_q[pfra_pkg::CFG_W-1:pfra_pkg::FRAME_SHIFT];
  assign nres     = (res_page > pfra_pkg::NRES_W'(pfra_pkg::BASE_PAGE))
                  ? res_page - pfra_pkg::NRES_W'(pfra_pkg::BASE_PAGE) : '0;
  assign fill_val = (pfra_pkg::CMP_W'(idx_q) < pfra_pkg::CMP_W'(nres))
                  ? pfra_pkg::RESERVED_COUNT : '0;

  always_comb begin
    new_count  = rdata;
    upd_status = pfra_pkg::ST_OK;
    case (op_q)
      pfra_pkg::OP_FREE: begin
        if (rdata == '0) begin
          upd_status = pfra_pkg::ST_ALREADY_FREE;
        end else begin
          new_count = rdata - 1'b1;
        end
      end
      pfra_pkg::OP_SHARE: begin
        if (rdata == pfra_pkg::COUNT_MAX) begin
          upd_status = pfra_pkg::ST_SATURATED;
        end else begin
          new_count = rdata + 1'b1;
        end
      end
      default: begin
        new_count = rdata;
      end
    endcase
  end

  always_comb begin
    case (ctrl_i.rd_sel)
      pfra_pkg::RD_TOP:  raddr = pfra_pkg::IDX_TOP_VAL;
      pfra_pkg::RD_DOWN: raddr = idx_q - 1'b1;
      default:           raddr = frame_idx;
    endcase
  end

  assign waddr = (ctrl_i.wr_sel == pfra_pkg::WR_UPDATE) ? frame_idx : idx_q;

  always_comb begin
    case (ctrl_i.wr_sel)
      pfra_pkg::WR_FILL:   wdata = fill_val;
      pfra_pkg::WR_ONE:    wdata = pfra_pkg::COUNT_W'(1);
      pfra_pkg::WR_UPDATE: wdata = new_count;
      default:             wdata = '0;
    endcase
  end

  pfra_ram #(
    .WIDTH(pfra_pkg::COUNT_W),
    .DEPTH(pfra_pkg::NUM_FRAMES)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign found_page = pfra_pkg::PAGE_W'(idx_q) + pfra_pkg::PAGE_W'(pfra_pkg::BASE_PAGE);

  always_comb begin
    result_d = '0;
    case (ctrl_i.res_sel)
      pfra_pkg::RES_UPDATE: begin
        result_d.ref_count = new_count;
        result_d.status    = upd_status;
      end
      pfra_pkg::RES_FOUND: begin
        result_d.frame_address = {found_page, {pfra_pkg::FRAME_SHIFT{1'b0}}};
        result_d.ref_count     = pfra_pkg::COUNT_W'(1);
        result_d.status        = pfra_pkg::ST_OK;
      end
      pfra_pkg::RES_NO_FREE: begin
        result_d.status = pfra_pkg::ST_NO_FREE;
      end
      pfra_pkg::RES_RANGE: begin
        result_d.status = pfra_pkg::ST_RANGE;
      end
      default: begin
        result_d.status = pfra_pkg::ST_OK;
      end
    endcase
  end

  assign stat_o.op       = op_q;
  assign stat_o.in_range = in_range;
  assign stat_o.rd_zero  = (rdata == '0);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.idx_top  = (idx_q == pfra_pkg::IDX_TOP_VAL);

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

// ----- hw/rtl/pfra_ctrl.sv -----
module pfra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pfra_pkg::stat_t stat_i,
  output pfra_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_UPDATE   = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_FILL     = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    ctrl_o.idx_op   = pfra_pkg::IDX_HOLD;
    ctrl_o.rd_sel   = pfra_pkg::RD_FRAME;
    ctrl_o.wr_sel   = pfra_pkg::WR_ZERO;
    ctrl_o.res_sel  = pfra_pkg::RES_OK;
    case (state_q)
      S_CLEAR: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = pfra_pkg::WR_ZERO;
        ctrl_o.idx_op = pfra_pkg::IDX_INC;
        if (stat_i.idx_top) begin
          ctrl_o.idx_op = pfra_pkg::IDX_ZERO;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.cmd_load = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.op)
          pfra_pkg::OP_ALLOC: begin
            ctrl_o.rd_en  = 1'b1;
            ctrl_o.rd_sel = pfra_pkg::RD_TOP;
            ctrl_o.idx_op = pfra_pkg::IDX_TOP;
            state_d       = S_SCAN;
          end
          pfra_pkg::OP_FREE, pfra_pkg::OP_SHARE, pfra_pkg::OP_QUERY: begin
            if (stat_i.in_range) begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = pfra_pkg::RD_FRAME;
              state_d       = S_UPDATE;
            end else begin
              ctrl_o.res_load = 1'b1;
              ctrl_o.res_sel  = pfra_pkg::RES_RANGE;
              state_d         = S_IDLE;
            end
          end
          pfra_pkg::OP_INIT: begin
            ctrl_o.idx_op = pfra_pkg::IDX_ZERO;
            state_d       = S_FILL;
          end
          default: begin
            ctrl_o.res_load = 1'b1;
            ctrl_o.res_sel  = pfra_pkg::RES_RANGE;
            state_d         = S_IDLE;
          end
        endcase
      end
      S_UPDATE: begin
        ctrl_o.wr_en    = 1'b1;
        ctrl_o.wr_sel   = pfra_pkg::WR_UPDATE;
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_sel  = pfra_pkg::RES_UPDATE;
        state_d         = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.rd_zero) begin
          ctrl_o.wr_en    = 1'b1;
          ctrl_o.wr_sel   = pfra_pkg::WR_ONE;
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_sel  = pfra_pkg::RES_FOUND;
          state_d         = S_IDLE;
        end else if (stat_i.idx_zero) begin
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_sel  = pfra_pkg::RES_NO_FREE;
          state_d         = S_IDLE;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = pfra_pkg::RD_DOWN;
          ctrl_o.idx_op = pfra_pkg::IDX_DEC;
        end
      end
      S_FILL: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = pfra_pkg::WR_FILL;
        ctrl_o.idx_op = pfra_pkg::IDX_INC;
        if (stat_i.idx_top) begin
          ctrl_o.idx_op   = pfra_pkg::IDX_ZERO;
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_sel  = pfra_pkg::RES_OK;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/page_frame_refcount_allocator_unit.sv -----
// From accept to result: an out-of-range or unknown op gets its result at dispatch;
// free, share and query read the frame's count, then write it back; alloc inspects
// frames top down (up to 3840), init fills all: one frame per cycle in the count memory.
// A new command is taken in the cycle the result strobe is high.
// Reset: async, active low; a pass that zeroes every count follows with busy_o high.
// Results are not held: the receiver takes each one in its strobe cycle.
module page_frame_refcount_allocator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  pfra_pkg::in_item_t                in_item_i,
  output pfra_pkg::out_item_t               result_o,
  output logic                              result_valid_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfra_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfra_pkg::CFG_W-1:0]        cfg_data_i
);

  pfra_pkg::ctrl_t ctrl;
  pfra_pkg::stat_t stat;
  logic            busy;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = busy;

  pfra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  pfra_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_item_i     (in_item_i),
    .cfg_write_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule
